### hdl/stl_pkg.sv
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, token class codes and character helpers for the token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  localparam int unsigned KEYWORD_CHARS = 6;
  localparam int unsigned KW_BITS       = 8 * KEYWORD_CHARS;
  localparam int unsigned KW_COUNT      = 13;
  localparam int unsigned MAX_TOKENS    = 4;

  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // token classes
  localparam logic [5:0] CL_END     = 6'd0;
  localparam logic [5:0] CL_NUMBER  = 6'd1;
  localparam logic [5:0] CL_IDENT   = 6'd2;
  localparam logic [5:0] CL_IF      = 6'd3;
  localparam logic [5:0] CL_ELSE    = 6'd4;
  localparam logic [5:0] CL_WHILE   = 6'd5;
  localparam logic [5:0] CL_FN      = 6'd6;
  localparam logic [5:0] CL_RETURN  = 6'd7;
  localparam logic [5:0] CL_FOR     = 6'd8;
  localparam logic [5:0] CL_INT     = 6'd9;
  localparam logic [5:0] CL_DOUBLE  = 6'd10;
  localparam logic [5:0] CL_REF     = 6'd11;
  localparam logic [5:0] CL_STRTYPE = 6'd12;
  localparam logic [5:0] CL_ARRAY   = 6'd13;
  localparam logic [5:0] CL_BOOL    = 6'd14;
  localparam logic [5:0] CL_STRING  = 6'd15;
  localparam logic [5:0] CL_ADD     = 6'd16;
  localparam logic [5:0] CL_ADD_EQ  = 6'd17;
  localparam logic [5:0] CL_INC     = 6'd18;
  localparam logic [5:0] CL_SUB     = 6'd19;
  localparam logic [5:0] CL_SUB_EQ  = 6'd20;
  localparam logic [5:0] CL_DEC     = 6'd21;
  localparam logic [5:0] CL_MUL     = 6'd22;
  localparam logic [5:0] CL_MUL_EQ  = 6'd23;
  localparam logic [5:0] CL_DIV     = 6'd24;
  localparam logic [5:0] CL_DIV_EQ  = 6'd25;
  localparam logic [5:0] CL_ASSIGN  = 6'd26;
  localparam logic [5:0] CL_EQ      = 6'd27;
  localparam logic [5:0] CL_NOT     = 6'd28;
  localparam logic [5:0] CL_NE      = 6'd29;
  localparam logic [5:0] CL_LT      = 6'd30;
  localparam logic [5:0] CL_LE      = 6'd31;
  localparam logic [5:0] CL_GT      = 6'd32;
  localparam logic [5:0] CL_GE      = 6'd33;
  localparam logic [5:0] CL_BOR     = 6'd34;
  localparam logic [5:0] CL_LOR     = 6'd35;
  localparam logic [5:0] CL_BAND    = 6'd36;
  localparam logic [5:0] CL_LAND    = 6'd37;
  localparam logic [5:0] CL_TILDE   = 6'd38;
  localparam logic [5:0] CL_DOLLAR  = 6'd39;
  localparam logic [5:0] CL_LBRACE  = 6'd40;
  localparam logic [5:0] CL_RBRACE  = 6'd41;
  localparam logic [5:0] CL_LBRACK  = 6'd42;
  localparam logic [5:0] CL_RBRACK  = 6'd43;
  localparam logic [5:0] CL_LPAREN  = 6'd44;
  localparam logic [5:0] CL_RPAREN  = 6'd45;
  localparam logic [5:0] CL_COMMA   = 6'd46;
  localparam logic [5:0] CL_SEMI    = 6'd47;
  localparam logic [5:0] CL_QUEST   = 6'd48;
  localparam logic [5:0] CL_COLON   = 6'd49;
  localparam logic [5:0] CL_DOT     = 6'd50;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_UNTERM     = 2'd2;

  // keyword words, first character in the low byte
  localparam logic [KW_BITS-1:0] KW_WORD [KW_COUNT] = '{
    KW_BITS'(48'h6669),         KW_BITS'(48'h65736c65),
    KW_BITS'(48'h656c696877),   KW_BITS'(48'h6e66),
    KW_BITS'(48'h6e7275746572), KW_BITS'(48'h726f66),
    KW_BITS'(48'h746e69),       KW_BITS'(48'h656c62756f64),
    KW_BITS'(48'h666572),       KW_BITS'(48'h676e69727473),
    KW_BITS'(48'h7961727261),   KW_BITS'(48'h65757274),
    KW_BITS'(48'h65736c6166)
  };
  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd5, 3'd2, 3'd6, 3'd3, 3'd3, 3'd6, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
  };
  localparam logic [5:0] KW_CLS [KW_COUNT] = '{
    CL_IF, CL_ELSE, CL_WHILE, CL_FN, CL_RETURN, CL_FOR, CL_INT, CL_DOUBLE,
    CL_REF, CL_STRTYPE, CL_ARRAY, CL_BOOL, CL_BOOL
  };
  localparam logic KW_BV [KW_COUNT] = '{
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0
  };

  typedef struct packed {
    logic [5:0]  cls;
    logic        bv;
    logic [1:0]  err;
    logic [15:0] off;
    logic [15:0] len;
    logic [15:0] line;
    logic [15:0] col;
  } stl_tok_t;

  // tokens of one transaction, handed from the step logic to the result bank
  typedef struct packed {
    stl_tok_t [MAX_TOKENS-1:0] tok;
    logic [2:0]                cnt;
  } stl_batch_t;

  function automatic stl_tok_t mk_tok(input logic [5:0] cls, input logic bv,
                                      input logic [15:0] off, input logic [15:0] len,
                                      input logic [15:0] line, input logic [15:0] col,
                                      input logic [1:0] err);
    stl_tok_t t;
    t.cls  = cls;
    t.bv   = bv;
    t.err  = err;
    t.off  = off;
    t.len  = len;
    t.line = line;
    t.col  = col;
    return t;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] x);
    return (x != POS_MAX) ? x + 16'd1 : x;
  endfunction

  function automatic logic [15:0] sat_len(input logic [16:0] e, input logic [15:0] s);
    logic [16:0] d;
    d = (e > {1'b0, s}) ? e - {1'b0, s} : '0;
    return (d > {1'b0, POS_MAX}) ? POS_MAX : d[15:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == "_");
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic can_pair(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") || (c == "=") ||
           (c == "!") || (c == "<") || (c == ">") || (c == "|") || (c == "&");
  endfunction

  function automatic logic [5:0] single_code(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      "+":     r = CL_ADD;
      "-":     r = CL_SUB;
      "*":     r = CL_MUL;
      "/":     r = CL_DIV;
      "=":     r = CL_ASSIGN;
      "!":     r = CL_NOT;
      "<":     r = CL_LT;
      ">":     r = CL_GT;
      "|":     r = CL_BOR;
      "&":     r = CL_BAND;
      "~":     r = CL_TILDE;
      "$":     r = CL_DOLLAR;
      "{":     r = CL_LBRACE;
      "}":     r = CL_RBRACE;
      "[":     r = CL_LBRACK;
      "]":     r = CL_RBRACK;
      "(":     r = CL_LPAREN;
      ")":     r = CL_RPAREN;
      ",":     r = CL_COMMA;
      ";":     r = CL_SEMI;
      "?":     r = CL_QUEST;
      ":":     r = CL_COLON;
      ".":     r = CL_DOT;
      default: r = CL_END;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] pair_code(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] r;
    r = CL_END;
    if (b == "=") begin
      case (a)
        "+":     r = CL_ADD_EQ;
        "-":     r = CL_SUB_EQ;
        "*":     r = CL_MUL_EQ;
        "/":     r = CL_DIV_EQ;
        "=":     r = CL_EQ;
        "!":     r = CL_NE;
        "<":     r = CL_LE;
        ">":     r = CL_GE;
        default: r = CL_END;
      endcase
    end else if ((a == "+") && (b == "+")) begin
      r = CL_INC;
    end else if ((a == "-") && (b == "-")) begin
      r = CL_DEC;
    end else if ((a == "|") && (b == "|")) begin
      r = CL_LOR;
    end else if ((a == "&") && (b == "&")) begin
      r = CL_LAND;
    end
    return r;
  endfunction

  // returns {class, bool value} of a finished word
  function automatic logic [6:0] kw_lookup(input logic [KW_BITS-1:0] w, input logic [2:0] n);
    logic [6:0] r;
    logic       hit;
    r   = {CL_IDENT, 1'b0};
    hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!hit && (n == KW_LEN[k]) && (w == KW_WORD[k])) begin
        r   = {KW_CLS[k], KW_BV[k]};
        hit = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

### hdl/stl_core.sv
// ----------------------------------------------------------------------------
// stl_core
// Lexer state register and the single-pass step that turns one character
// transaction into up to four tokens.
// ----------------------------------------------------------------------------
module stl_core import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] char_code_i,
  input  logic       end_of_input_i,
  input  logic       char_present_i,
  output stl_batch_t batch_o
);

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_OP, M_STR, M_INT, M_DOT, M_FRAC, M_EXPE, M_EXPS, M_EXPD
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic [7:0]         pend;
    logic [KW_BITS-1:0] wbuf;
    logic [2:0]         wcnt;
    logic [1:0]         held;
    logic               bsl;
    logic               errl;
    logic [15:0]        coff;
    logic [15:0]        cline;
    logic [15:0]        ccol;
    logic [15:0]        soff;
    logic [15:0]        sline;
    logic [15:0]        scol;
  } lx_t;

  typedef stl_tok_t [7:0] tlist_t;

  lx_t        st_q, st_d;
  tlist_t     list_d;
  logic [3:0] n_d;
  logic [6:0] kw_end;

  function automatic lx_t lx_reset();
    lx_t s;
    s       = '0;
    s.mode  = M_IDLE;
    s.cline = 16'd1;
    s.ccol  = 16'd1;
    s.sline = 16'd1;
    s.scol  = 16'd1;
    return s;
  endfunction

  function automatic void push(inout tlist_t l, inout logic [3:0] n, input stl_tok_t t);
    if (n < 4'd8) begin
      l[n[2:0]] = t;
      n         = n + 4'd1;
    end
  endfunction

  function automatic stl_tok_t tok_at(input lx_t s, input logic [5:0] cls,
                                      input logic bv, input logic [15:0] len);
    return mk_tok(cls, bv, s.soff, len, s.sline, s.scol, ERR_NONE);
  endfunction

  function automatic void hold(inout lx_t s, input logic [7:0] c);
    if (s.held != 2'd3) begin
      for (int i = 0; i < 3; i++) begin
        if (s.held == 2'(i)) s.wbuf[8*i +: 8] = s.wbuf[8*i +: 8] | c;
      end
      s.held = s.held + 2'd1;
    end
  endfunction

  function automatic logic is_num(input mode_e m);
    return m inside {M_INT, M_DOT, M_FRAC, M_EXPE, M_EXPS, M_EXPD};
  endfunction

  // character ends the number being scanned
  function automatic logic num_break(input mode_e m, input logic [7:0] c);
    logic r;
    case (m)
      M_INT, M_DOT, M_FRAC: r = !is_digit(c) && !((c == ".") && (m == M_INT)) &&
                                !((c == "e") || (c == "E"));
      M_EXPE, M_EXPS:       r = !is_digit(c) && !((m == M_EXPE) && ((c == "+") || (c == "-")));
      M_EXPD:               r = !is_digit(c);
      default:              r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic void feed(inout lx_t s, inout tlist_t l, inout logic [3:0] n,
                               input logic [7:0] c, input logic [15:0] p,
                               input logic [15:0] ln, input logic [15:0] cl);
    logic       go;
    logic [5:0] code;
    logic [6:0] kw;
    go   = 1'b0;
    code = pair_code(s.pend, c);
    kw   = kw_lookup(s.wbuf, s.wcnt);
    if (!s.errl) begin
      unique case (s.mode)
        M_IDENT: begin
          if (is_word(c)) begin
            for (int i = 0; i < KEYWORD_CHARS; i++) begin
              if (s.wcnt == 3'(i)) s.wbuf[8*i +: 8] = s.wbuf[8*i +: 8] | c;
            end
            if (s.wcnt <= 3'(KEYWORD_CHARS)) s.wcnt = s.wcnt + 3'd1;
          end else begin
            push(l, n, tok_at(s, kw[6:1], kw[0], sat_len({1'b0, p}, s.soff)));
            s.mode = M_IDLE;
            go     = 1'b1;
          end
        end
        M_OP: begin
          if (code != CL_END) begin
            push(l, n, tok_at(s, code, 1'b0, sat_len({1'b0, p} + 17'd1, s.soff)));
          end else begin
            push(l, n, tok_at(s, single_code(s.pend), 1'b0, 16'd1));
            go = 1'b1;
          end
          s.mode = M_IDLE;
          s.pend = '0;
        end
        M_STR: begin
          if ((c == "\"") && !s.bsl) begin
            push(l, n, tok_at(s, CL_STRING, 1'b0, sat_len({1'b0, p} + 17'd1, s.soff)));
            s.mode = M_IDLE;
            s.bsl  = 1'b0;
          end else begin
            s.bsl = (c == "\\");
          end
        end
        M_INT, M_DOT, M_FRAC: begin
          if (is_digit(c)) begin
            if (s.mode == M_DOT) begin
              s.mode = M_FRAC;
              s.held = '0;
              s.wbuf = '0;
            end
          end else if ((c == ".") && (s.mode == M_INT)) begin
            s.mode = M_DOT;
            hold(s, c);
          end else if ((c == "e") || (c == "E")) begin
            s.mode = M_EXPE;
            hold(s, c);
          end
        end
        M_EXPE, M_EXPS: begin
          if (is_digit(c)) begin
            s.mode = M_EXPD;
            s.held = '0;
            s.wbuf = '0;
          end else if ((s.mode == M_EXPE) && ((c == "+") || (c == "-"))) begin
            s.mode = M_EXPS;
            hold(s, c);
          end
        end
        M_EXPD: ;
        default: begin
          s.mode = M_IDLE;
          go     = 1'b1;
        end
      endcase
      if (go && !is_space(c)) begin
        s.soff  = p;
        s.sline = ln;
        s.scol  = cl;
        if (is_digit(c)) begin
          s.mode = M_INT;
          s.held = '0;
          s.wbuf = '0;
        end else if (is_alpha(c) || (c == "_")) begin
          s.mode = M_IDENT;
          s.wbuf = KW_BITS'(c);
          s.wcnt = 3'd1;
        end else if (c == "\"") begin
          s.mode = M_STR;
          s.bsl  = 1'b0;
        end else if (can_pair(c)) begin
          s.mode = M_OP;
          s.pend = c;
        end else if (single_code(c) != CL_END) begin
          push(l, n, tok_at(s, single_code(c), 1'b0, 16'd1));
        end else begin
          push(l, n, mk_tok(CL_END, 1'b0, p, 16'd1, ln, cl, ERR_UNEXPECTED));
          s.errl = 1'b1;
          s.mode = M_IDLE;
        end
      end
    end
  endfunction

  // emit the number up to its held tail, then lex the held characters again
  function automatic void number_break(inout lx_t s, inout tlist_t l, inout logic [3:0] n,
                                       input logic [15:0] p, input logic [15:0] ln,
                                       input logic [15:0] cl);
    logic [1:0]  h;
    logic [23:0] saved;
    logic [15:0] endp;
    logic [15:0] back;
    logic [15:0] o;
    logic [15:0] col;
    h     = s.held;
    saved = s.wbuf[23:0];
    endp  = (p >= 16'(h)) ? p - 16'(h) : '0;
    push(l, n, tok_at(s, CL_NUMBER, 1'b0, sat_len({1'b0, endp}, s.soff)));
    s.mode = M_IDLE;
    s.held = '0;
    s.wbuf = '0;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < h) begin
        back = 16'(h) - 16'(k);
        o    = (p >= back) ? p - back : '0;
        col  = (cl > back) ? cl - back : 16'd1;
        feed(s, l, n, saved[8*k +: 8], o, ln, col);
      end
    end
  endfunction

  always_comb begin
    st_d   = st_q;
    list_d = '0;
    n_d    = '0;
    kw_end = '0;
    if (char_present_i) begin
      if (!st_d.errl && num_break(st_d.mode, char_code_i)) begin
        number_break(st_d, list_d, n_d, st_q.coff, st_q.cline, st_q.ccol);
      end
      feed(st_d, list_d, n_d, char_code_i, st_q.coff, st_q.cline, st_q.ccol);
      st_d.coff = sat_inc(st_q.coff);
      if (char_code_i == "\n") begin
        st_d.cline = sat_inc(st_q.cline);
        st_d.ccol  = 16'd1;
      end else begin
        st_d.ccol = sat_inc(st_q.ccol);
      end
    end
    if (end_of_input_i) begin
      if (!st_d.errl && is_num(st_d.mode)) begin
        number_break(st_d, list_d, n_d, st_d.coff, st_d.cline, st_d.ccol);
      end
      kw_end = kw_lookup(st_d.wbuf, st_d.wcnt);
      if (!st_d.errl) begin
        case (st_d.mode)
          M_IDENT: push(list_d, n_d, tok_at(st_d, kw_end[6:1], kw_end[0],
                                            sat_len({1'b0, st_d.coff}, st_d.soff)));
          M_OP:    push(list_d, n_d, tok_at(st_d, single_code(st_d.pend), 1'b0, 16'd1));
          M_STR:   push(list_d, n_d, mk_tok(CL_END, 1'b0, st_d.soff,
                                            sat_len({1'b0, st_d.coff}, st_d.soff),
                                            st_d.sline, st_d.scol, ERR_UNTERM));
          default: ;
        endcase
      end
      push(list_d, n_d, mk_tok(CL_END, 1'b0, st_d.coff, 16'd0, st_d.cline, st_d.ccol,
                               ERR_NONE));
      st_d = lx_reset();
    end
    // overflow keeps the first three and the last
    if (n_d > 4'd4) begin
      list_d[3] = list_d[3'(n_d - 4'd1)];
      n_d       = 4'd4;
    end
    for (int i = 0; i < MAX_TOKENS; i++) begin
      batch_o.tok[i] = list_d[i];
    end
    batch_o.cnt = n_d[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lx_reset();
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

### hdl/stl_rbuf.sv
// ----------------------------------------------------------------------------
// stl_rbuf
// Result bank: holds the tokens of one transaction and hands them out in order.
// ----------------------------------------------------------------------------
module stl_rbuf import stl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  stl_batch_t batch_i,
  input  logic       ready_i,
  output logic       valid_o,
  output stl_tok_t   tok_o,
  output logic       last_o,
  output logic       free_o
);

  stl_tok_t   bank_q [MAX_TOKENS];
  logic [2:0] rem_q;
  logic [1:0] rd_q;
  logic       pop;

  assign valid_o = (rem_q != 3'd0);
  assign pop     = valid_o && ready_i;
  assign tok_o   = bank_q[rd_q];
  assign last_o  = (rem_q == 3'd1);
  assign free_o  = (rem_q == 3'd0) || ((rem_q == 3'd1) && ready_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < MAX_TOKENS; i++) begin
        bank_q[i] <= batch_i.tok[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      rd_q  <= '0;
    end else if (load_i) begin
      rem_q <= batch_i.cnt;
      rd_q  <= '0;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd4)
    else $error("result bank count out of range");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (rem_q == 3'd0) || ((rem_q == 3'd1) && ready_i))
    else $error("result bank loaded while tokens still pending");

  a_load_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_i && (batch_i.cnt != 3'd0)) |=> (valid_o && (rd_q == 2'd0)))
    else $error("loaded tokens not presented from the first slot");

endmodule

### hdl/script_token_lexer.sv
// ----------------------------------------------------------------------------
// script_token_lexer
// Streaming lexer: one source character per transaction in, tokens out.
// ----------------------------------------------------------------------------
// The lexer takes one character transaction per cycle while the result bank
// can take its tokens. A character first lands in an input register; once the
// bank is free, a single combinational pass updates the scanner state and
// writes the tokens the character finishes (the first three and the last when
// there are more than four) into a four-slot result bank, which presents them
// one per cycle while out_ready_i is high on the output channel, the last one
// flagged with last_of_run_o. A held character waits in the input register
// while the bank drains, so the input side waits only on the result bank.
// The input register accepts a new character while the bank still shows the
// final token of the previous one. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module script_token_lexer import stl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_input_i,
  input  logic        char_present_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_class_o,
  output logic        bool_value_o,
  output logic [15:0] start_offset_o,
  output logic [15:0] token_length_o,
  output logic [15:0] line_number_o,
  output logic [15:0] column_number_o,
  output logic [1:0]  error_code_o,
  output logic        last_of_run_o
);

  // input register
  logic       in_vld_q;
  logic [7:0] in_char_q;
  logic       in_end_q;
  logic       in_pres_q;

  logic       fire;
  logic       bank_free;
  stl_batch_t batch;
  stl_tok_t   tok;

  // step runs when a character is held and the bank can take its tokens
  assign fire       = in_vld_q && bank_free;
  assign in_ready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= char_code_i;
      in_end_q  <= end_of_input_i;
      in_pres_q <= char_present_i;
    end
  end

  stl_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .char_code_i    (in_char_q),
    .end_of_input_i (in_end_q),
    .char_present_i (in_pres_q),
    .batch_o        (batch)
  );

  stl_rbuf u_rbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire),
    .batch_i (batch),
    .ready_i (out_ready_i),
    .valid_o (out_valid_o),
    .tok_o   (tok),
    .last_o  (last_of_run_o),
    .free_o  (bank_free)
  );

  assign token_class_o   = tok.cls;
  assign bool_value_o    = tok.bv;
  assign start_offset_o  = tok.off;
  assign token_length_o  = tok.len;
  assign line_number_o   = tok.line;
  assign column_number_o = tok.col;
  assign error_code_o    = tok.err;

endmodule

### dv/script_token_lexer_test.sv
// ----------------------------------------------------------------------------
// script_token_lexer_test
// Self-checking bench: streams short source programs through the lexer,
// predicts every token in a local scanner model and scoreboards the output.
// ----------------------------------------------------------------------------
module script_token_lexer_test;
  import stl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // scanner modes of the predictor
  localparam int S_IDLE  = 0;
  localparam int S_IDENT = 1;
  localparam int S_OP    = 2;
  localparam int S_STR   = 3;
  localparam int S_INT   = 4;
  localparam int S_DOT   = 5;
  localparam int S_FRAC  = 6;
  localparam int S_EXPE  = 7;
  localparam int S_EXPS  = 8;
  localparam int S_EXPD  = 9;

  localparam int unsigned PMAX = 65535;

  typedef struct {
    logic [7:0] code;
    logic       eoi;
    logic       pres;
    bit         drain;  // hold off until all tokens are out
  } char_txn_t;

  typedef struct {
    stl_tok_t tok;
    logic     last;
  } tok_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_code_i = '0;
  logic        end_of_input_i = 1'b0;
  logic        char_present_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [5:0]  token_class_o;
  logic        bool_value_o;
  logic [15:0] start_offset_o;
  logic [15:0] token_length_o;
  logic [15:0] line_number_o;
  logic [15:0] column_number_o;
  logic [1:0]  error_code_o;
  logic        last_of_run_o;

  script_token_lexer u_top (.*);

  always #10 clk_i = ~clk_i;

  char_txn_t src_q[$];   // characters waiting to be sent
  tok_exp_t  tok_q[$];   // tokens predicted, not yet seen
  bit        failed;
  bit        sent;       // current character was taken at the last rising edge
  int        in_gap;
  int        out_gap;
  bit        in_burst;   // stretches with no idling on the input
  bit        out_burst;

  // --------------------------------------------------------------------------
  // Scanner predictor
  // --------------------------------------------------------------------------
  int          mode, held, wcount;
  logic [7:0]  pend_op;
  logic [47:0] wbuf;
  bit          prev_bs, err_lat;
  int unsigned c_off, c_line, c_col, t_off, t_line, t_col;
  stl_tok_t    step_toks[$];

  string kw_text[13] = '{"if", "else", "while", "fn", "return", "for", "int",
                         "double", "ref", "string", "array", "true", "false"};
  logic [5:0] kw_cls[13] = '{CL_IF, CL_ELSE, CL_WHILE, CL_FN, CL_RETURN, CL_FOR,
                             CL_INT, CL_DOUBLE, CL_REF, CL_STRTYPE, CL_ARRAY,
                             CL_BOOL, CL_BOOL};

  function automatic void scan_reset();
    mode = S_IDLE; pend_op = '0; wbuf = '0; held = 0; wcount = 0;
    prev_bs = 0; err_lat = 0;
    c_off = 0; c_line = 1; c_col = 1; t_off = 0; t_line = 1; t_col = 1;
  endfunction

  function automatic int unsigned bump(int unsigned x);
    return (x < PMAX) ? x + 1 : x;
  endfunction

  function automatic int unsigned span(int unsigned e, int unsigned s);
    int unsigned d;
    d = (e > s) ? e - s : 0;
    return (d > PMAX) ? PMAX : d;
  endfunction

  function automatic void push_tok(logic [5:0] cls, logic bv, int unsigned off,
                                   int unsigned len, int unsigned ln,
                                   int unsigned cl, logic [1:0] err);
    stl_tok_t t;
    if (step_toks.size() >= 8) return;
    t.cls = cls; t.bv = bv; t.err = err;
    t.off = off[15:0]; t.len = len[15:0]; t.line = ln[15:0]; t.col = cl[15:0];
    step_toks.insert(step_toks.size(), t);
  endfunction

  function automatic void push_here(logic [5:0] cls, logic bv, int unsigned len);
    push_tok(cls, bv, t_off, len, t_line, t_col, ERR_NONE);
  endfunction

  function automatic bit dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [5:0] op1(logic [7:0] c);
    case (c)
      "+": return CL_ADD;     "-": return CL_SUB;     "*": return CL_MUL;
      "/": return CL_DIV;     "=": return CL_ASSIGN;  "!": return CL_NOT;
      "<": return CL_LT;      ">": return CL_GT;      "|": return CL_BOR;
      "&": return CL_BAND;    "~": return CL_TILDE;   "$": return CL_DOLLAR;
      "{": return CL_LBRACE;  "}": return CL_RBRACE;  "[": return CL_LBRACK;
      "]": return CL_RBRACK;  "(": return CL_LPAREN;  ")": return CL_RPAREN;
      ",": return CL_COMMA;   ";": return CL_SEMI;    "?": return CL_QUEST;
      ":": return CL_COLON;   ".": return CL_DOT;
      default: return CL_END;
    endcase
  endfunction

  function automatic logic [5:0] op2(logic [7:0] a, logic [7:0] b);
    if (b == "=") begin
      case (a)
        "+": return CL_ADD_EQ;  "-": return CL_SUB_EQ;  "*": return CL_MUL_EQ;
        "/": return CL_DIV_EQ;  "=": return CL_EQ;      "!": return CL_NE;
        "<": return CL_LE;      ">": return CL_GE;
        default: return CL_END;
      endcase
    end
    if (a == b && (a == "+" || a == "-" || a == "|" || a == "&")) begin
      case (a)
        "+": return CL_INC;
        "-": return CL_DEC;
        "|": return CL_LOR;
        default: return CL_LAND;
      endcase
    end
    return CL_END;
  endfunction

  // word done: keyword lookup on the first six characters plus the count
  function automatic void close_word(int unsigned p);
    logic [5:0]  cls;
    logic        bv;
    logic [47:0] packed_w;
    cls = CL_IDENT; bv = 0;
    for (int k = 12; k >= 0; k--) begin
      packed_w = '0;
      for (int n = 0; n < kw_text[k].len(); n++) packed_w[8*n +: 8] = kw_text[k][n];
      if (kw_text[k].len() == wcount && packed_w == wbuf) begin
        cls = kw_cls[k]; bv = (k == 11);
      end
    end
    push_here(cls, bv, span(p, t_off));
    mode = S_IDLE;
  endfunction

  function automatic void hold_char(logic [7:0] c);
    if (held < 3) begin
      wbuf[8*held +: 8] = c;
      held++;
    end
  endfunction

  // number ended early: emit the digits and relex the held tail
  function automatic void give_back(int unsigned p, int unsigned ln, int unsigned cl);
    int          h;
    logic [47:0] saved;
    int unsigned back;
    h = held; saved = wbuf;
    push_here(CL_NUMBER, 0, span((p >= h) ? p - h : 0, t_off));
    mode = S_IDLE; held = 0; wbuf = '0;
    for (int k = 0; k < h; k++) begin
      back = h - k;
      scan_char(saved[8*k +: 8], (p >= back) ? p - back : 0, ln,
                (cl > back) ? cl - back : 1);
    end
  endfunction

  function automatic void scan_char(logic [7:0] c, int unsigned p, int unsigned ln,
                                    int unsigned cl);
    logic [5:0] code;
    if (err_lat) return;
    case (mode)
      S_IDENT: begin
        if (alpha(c) || dig(c) || c == "_") begin
          if (wcount < 6) wbuf[8*wcount +: 8] = c;
          if (wcount <= 6) wcount++;
          return;
        end
        close_word(p);
      end
      S_OP: begin
        code = op2(pend_op, c);
        mode = S_IDLE;
        if (code != CL_END) begin
          push_here(code, 0, span(p + 1, t_off));
          pend_op = '0;
          return;
        end
        push_here(op1(pend_op), 0, 1);
        pend_op = '0;
      end
      S_STR: begin
        if (c == "\"" && !prev_bs) begin
          push_here(CL_STRING, 0, span(p + 1, t_off));
          mode = S_IDLE; prev_bs = 0;
          return;
        end
        prev_bs = (c == "\\");
        return;
      end
      S_INT, S_FRAC, S_DOT: begin
        if (dig(c)) begin
          if (mode == S_DOT) begin
            mode = S_FRAC; held = 0; wbuf = '0;
          end
          return;
        end
        if (c == "." && mode == S_INT) begin
          mode = S_DOT; hold_char(c); return;
        end
        if (c == "e" || c == "E") begin
          mode = S_EXPE; hold_char(c); return;
        end
        give_back(p, ln, cl); scan_char(c, p, ln, cl);
        return;
      end
      S_EXPE, S_EXPS: begin
        if (dig(c)) begin
          mode = S_EXPD; held = 0; wbuf = '0; return;
        end
        if (mode == S_EXPE && (c == "+" || c == "-")) begin
          mode = S_EXPS; hold_char(c); return;
        end
        give_back(p, ln, cl); scan_char(c, p, ln, cl);
        return;
      end
      S_EXPD: begin
        if (dig(c)) return;
        give_back(p, ln, cl); scan_char(c, p, ln, cl);
        return;
      end
      default: mode = S_IDLE;
    endcase
    // between tokens
    if (c == " " || (c >= 9 && c <= 13)) return;
    t_off = p; t_line = ln; t_col = cl;
    if (dig(c)) begin
      mode = S_INT; held = 0; wbuf = '0;
    end else if (alpha(c) || c == "_") begin
      mode = S_IDENT; wbuf = 48'(c); wcount = 1;
    end else if (c == "\"") begin
      mode = S_STR; prev_bs = 0;
    end else if (op2(c, "=") != CL_END || c == "|" || c == "&") begin
      mode = S_OP; pend_op = c;
    end else if (op1(c) != CL_END) begin
      push_here(op1(c), 0, 1);
    end else begin
      push_tok(CL_END, 0, p, 1, ln, cl, ERR_UNEXPECTED);
      err_lat = 1; mode = S_IDLE;
    end
  endfunction

  function automatic void flush_all();
    for (int g = 0; g < 8 && mode != S_IDLE && !err_lat; g++) begin
      case (mode)
        S_IDENT: close_word(c_off);
        S_OP: begin
          push_here(op1(pend_op), 0, 1);
          mode = S_IDLE; pend_op = '0;
        end
        S_STR: begin
          push_tok(CL_END, 0, t_off, span(c_off, t_off), t_line, t_col, ERR_UNTERM);
          mode = S_IDLE;
        end
        default: give_back(c_off, c_line, c_col);
      endcase
    end
    push_tok(CL_END, 0, c_off, 0, c_line, c_col, ERR_NONE);
  endfunction

  // one accepted character transaction -> expected tokens
  function automatic void predict_tokens(logic [7:0] c, logic eoi, logic pres);
    tok_exp_t e;
    int       n;
    step_toks.delete();
    if (pres) begin
      scan_char(c, c_off, c_line, c_col);
      c_off = bump(c_off);
      if (c == 8'h0A) begin
        c_line = bump(c_line); c_col = 1;
      end else begin
        c_col = bump(c_col);
      end
    end
    if (eoi) begin
      flush_all();
      scan_reset();
    end
    n = step_toks.size();
    // over four: keep the first three and the very last
    if (n > MAX_TOKENS) begin
      step_toks[MAX_TOKENS-1] = step_toks[n-1];
      n = MAX_TOKENS;
    end
    for (int i = 0; i < n; i++) begin
      e.tok = step_toks[i];
      e.last = (i == n - 1);
      tok_q.insert(tok_q.size(), e);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  function automatic void add_char(logic [7:0] c, logic eoi = 0, logic pres = 1);
    char_txn_t t;
    t.code = c; t.eoi = eoi; t.pres = pres; t.drain = 0;
    src_q.insert(src_q.size(), t);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endfunction

  // close a program: end marker on the last character or as a bare transaction
  function automatic void add_end();
    if (src_q.size() != 0 && src_q[$].pres && !src_q[$].eoi && $urandom_range(0, 1))
      src_q[$].eoi = 1;
    else
      add_char(8'($urandom_range(0, 255)), 1, 0);
  endfunction

  string ops[32] = '{"+", "+=", "++", "-", "-=", "--", "*", "*=", "/", "/=", "=",
                     "==", "!", "!=", "<", "<=", ">", ">=", "|", "||", "&", "&&",
                     "~", "$", "{", "}", "[", "]", "(", ")", ",", ";"};
  string nums[10] = '{"0", "42", "3.", "4.5", "6e", "7E-", "8e+", "9.e+", "1.5e-12",
                      "2E7"};

  function automatic string rand_word();
    string s;
    int    n;
    s = "";
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: s = {s, string'(8'($urandom_range("a", "z")))};
        1: s = {s, string'(8'($urandom_range("A", "Z")))};
        2: s = {s, (i == 0) ? "_" : string'(8'($urandom_range("0", "9")))};
        default: s = {s, "_"};
      endcase
    end
    return s;
  endfunction

  function automatic void add_program();
    int n;
    n = $urandom_range(2, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: add_text(kw_text[$urandom_range(0, 12)]);
        3, 4:    add_text(rand_word());
        5, 6, 7: add_text(nums[$urandom_range(0, 9)]);
        8, 9, 10, 11: add_text(ops[$urandom_range(0, 31)]);
        12: add_text($urandom_range(0, 1) ? "?" : (($urandom_range(0, 1)) ? ":" : "."));
        13: add_text($urandom_range(0, 1) ? "\"a b\\\"c\"" : "\"x\\\\\"");
        14, 15: add_char(($urandom_range(0, 1)) ? " " : 8'($urandom_range(9, 13)));
        16: add_char(8'h0A);
        17: add_char(8'($urandom_range(0, 255)));        // noise
        18: add_char(8'($urandom_range(0, 255)), 0, 0);  // bare transaction
        default: add_text($urandom_range(0, 3) == 0 ? "\"open" : " ");
      endcase
    end
    add_end();
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    scan_reset();
    // directed: keywords, give-back, escaped quote, newline positions
    add_text("if true false\n_a9 \"q\\\"r\" 1.e+;");
    add_end();
    add_text("5. 7e-x \"open");   // unterminated string at the end
    add_char(8'h0A, 1, 1);
    add_char(8'h80, 0, 1);       // unexpected byte, rest ignored
    add_char("a");
    add_char(8'hFF, 1, 0);
    add_char(8'h00, 0, 0);       // bare transaction, no effect
    add_char(8'h7F, 1, 1);
    // random programs
    while (src_q.size() < 110) add_program();
    src_q[src_q.size() / 2].drain = 1;
  end

  // --------------------------------------------------------------------------
  // Reset, driver, output throttle
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(negedge clk_i) begin
    char_txn_t t;
    if (rst_ni) begin
      if (!in_valid_i || sent) begin
        sent = 0;
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (src_q.size() != 0 && !(src_q[0].drain && tok_q.size() != 0)) begin
          t = src_q.pop_front();
          char_code_i    <= t.code;
          end_of_input_i <= t.eoi;
          char_present_i <= t.pres;
          in_valid_i     <= 1'b1;
          if ($urandom_range(0, 15) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
      if (out_gap > 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (!out_burst) out_gap = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on input transactions, check output transactions
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tok_exp_t e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sent = 1;
        predict_tokens(char_code_i, end_of_input_i, char_present_i);
      end
      if (out_valid_o && out_ready_i) begin
        if (tok_q.size() == 0) begin
          $error("unexpected token transaction, class %0d", token_class_o);
          failed = 1;
        end else begin
          e = tok_q.pop_front();
          if (token_class_o !== e.tok.cls) begin
            $error("token_class exp %0d got %0d", e.tok.cls, token_class_o); failed = 1;
          end
          if (bool_value_o !== e.tok.bv) begin
            $error("bool_value exp %0d got %0d", e.tok.bv, bool_value_o); failed = 1;
          end
          if (start_offset_o !== e.tok.off) begin
            $error("start_offset exp %0d got %0d", e.tok.off, start_offset_o); failed = 1;
          end
          if (token_length_o !== e.tok.len) begin
            $error("token_length exp %0d got %0d", e.tok.len, token_length_o); failed = 1;
          end
          if (line_number_o !== e.tok.line) begin
            $error("line_number exp %0d got %0d", e.tok.line, line_number_o); failed = 1;
          end
          if (column_number_o !== e.tok.col) begin
            $error("column_number exp %0d got %0d", e.tok.col, column_number_o); failed = 1;
          end
          if (error_code_o !== e.tok.err) begin
            $error("error_code exp %0d got %0d", e.tok.err, error_code_o); failed = 1;
          end
          if (last_of_run_o !== e.last) begin
            $error("last_of_run exp %0d got %0d", e.last, last_of_run_o); failed = 1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // End of test and watchdog
  // --------------------------------------------------------------------------
  initial begin
    @(posedge rst_ni);
    while (src_q.size() != 0 || in_valid_i || tok_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (!failed && tok_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
